/* design/lfu_pkg.sv */
// Package for the LFU cache table: sizes, widths and the controller/datapath interface.
// Used by lfu_ctrl, lfu_datapath and lfu_cache_table_top; depends on nothing.
package lfu_pkg;

    localparam int ENTRIES = 16;
    localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int OCC_W = $clog2(ENTRIES + 1);
    localparam int CFG_W = 5;
    localparam int CMP_W = (OCC_W > CFG_W) ? OCC_W : CFG_W;
    localparam int DATA_W = 32;
    localparam int CNT_W = 32;
    localparam int IN_TDATA_W = 2 * DATA_W;

    localparam logic [CFG_W-1:0] CAP_RESET = CFG_W'(16);
    localparam logic [DATA_W-1:0] MISS_DATA = '1;
    localparam logic [CNT_W-1:0] CNT_MAX = '1;
    localparam logic [CNT_W-1:0] CNT_ONE = CNT_W'(1);

    localparam logic KIND_GET = 1'b0;
    localparam logic KIND_PUT = 1'b1;

    typedef struct packed {
        logic start;
        logic scan_en;
        logic update_en;
    } ctrl_cmd_t;

    typedef struct packed {
        logic scan_last;
    } ctrl_status_t;

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
        return (v == CNT_MAX) ? v : v + CNT_ONE;
    endfunction

endpackage

/* design/lfu_ctrl.sv */
// Controller of the LFU cache table: sequences accept, slot scan and write-back.
// Depends on lfu_pkg; drives the datapath through ctrl_cmd_t.
module lfu_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_valid,
    output logic                  s_ready,
    output logic                  m_valid,
    input  logic                  m_ready,
    input  lfu_pkg::ctrl_status_t status,
    output lfu_pkg::ctrl_cmd_t    cmd
);
    import lfu_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_UPDATE
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   m_valid_reg;
    logic   m_valid_next;
    logic   out_free;

    assign out_free = !m_valid_reg || m_ready;
    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;

    always_comb
    begin
        state_next = state_reg;
        m_valid_next = m_valid_reg && !m_ready;
        cmd = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_valid)
                begin
                    cmd.start = 1'b1;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                cmd.scan_en = 1'b1;
                if (status.scan_last)
                begin
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE:
            begin
                if (out_free)
                begin
                    cmd.update_en = 1'b1;
                    m_valid_next = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

endmodule

/* design/lfu_datapath.sv */
// Datapath of the LFU cache table: slot storage, sequential slot scan and write-back.
// Depends on lfu_pkg; controlled by lfu_ctrl through ctrl_cmd_t.
module lfu_datapath (
    input  logic                          clk,
    input  logic                          rst_n,
    input  lfu_pkg::ctrl_cmd_t            cmd,
    output lfu_pkg::ctrl_status_t         status,
    input  logic                          cfg_wr_en,
    input  logic [lfu_pkg::CFG_W-1:0]     cfg_wr_data,
    input  logic                          in_kind,
    input  logic signed [lfu_pkg::DATA_W-1:0] in_key,
    input  logic signed [lfu_pkg::DATA_W-1:0] in_data,
    output logic                          out_hit,
    output logic signed [lfu_pkg::DATA_W-1:0] out_data
);
    import lfu_pkg::*;

    logic [DATA_W-1:0] key_mem [ENTRIES];
    logic [DATA_W-1:0] data_mem [ENTRIES];
    logic [CNT_W-1:0]  count_mem [ENTRIES];
    logic [CNT_W-1:0]  stamp_mem [ENTRIES];
    logic [ENTRIES-1:0] valid_reg;
    logic [ENTRIES-1:0] valid_next;

    logic [CFG_W-1:0]  cfg_reg;
    logic [CNT_W-1:0]  clock_reg;
    logic [OCC_W-1:0]  occ_reg;
    logic [IDX_W-1:0]  scan_idx_reg;

    logic              item_kind_reg;
    logic [DATA_W-1:0] item_key_reg;
    logic [DATA_W-1:0] item_data_reg;

    logic              hit_found_reg;
    logic [IDX_W-1:0]  hit_slot_reg;
    logic [DATA_W-1:0] hit_data_reg;
    logic [CNT_W-1:0]  hit_count_reg;
    logic              vic_found_reg;
    logic [IDX_W-1:0]  vic_slot_reg;
    logic [CNT_W-1:0]  vic_count_reg;
    logic [CNT_W-1:0]  vic_stamp_reg;
    logic              free_found_reg;
    logic [IDX_W-1:0]  free_slot_reg;

    logic              out_hit_reg;
    logic [DATA_W-1:0] out_data_reg;

    logic              cur_valid;
    logic [DATA_W-1:0] cur_key;
    logic [DATA_W-1:0] cur_data;
    logic [CNT_W-1:0]  cur_count;
    logic [CNT_W-1:0]  cur_stamp;
    logic              key_match;
    logic              better_victim;

    logic [CMP_W-1:0]  cap;
    logic              cap_zero;
    logic              table_full;
    logic [CNT_W-1:0]  clock_new;
    logic              insert_ok;
    logic [IDX_W-1:0]  insert_slot;
    logic              wr_en;
    logic [IDX_W-1:0]  wr_slot;
    logic [DATA_W-1:0] wr_data;
    logic [CNT_W-1:0]  wr_count;
    logic              occ_inc;

    assign cur_valid = valid_reg[scan_idx_reg];
    assign cur_key = key_mem[scan_idx_reg];
    assign cur_data = data_mem[scan_idx_reg];
    assign cur_count = count_mem[scan_idx_reg];
    assign cur_stamp = stamp_mem[scan_idx_reg];
    assign key_match = cur_valid && (cur_key == item_key_reg);
    assign better_victim = cur_valid && (!vic_found_reg || (cur_count < vic_count_reg) ||
                           ((cur_count == vic_count_reg) && (cur_stamp < vic_stamp_reg)));

    assign status.scan_last = (scan_idx_reg == IDX_W'(ENTRIES - 1));

    always_comb
    begin
        if (CMP_W'(cfg_reg) > CMP_W'(ENTRIES))
        begin
            cap = CMP_W'(ENTRIES);
        end
        else
        begin
            cap = CMP_W'(cfg_reg);
        end
    end

    assign cap_zero = (cfg_reg == '0);
    assign table_full = (CMP_W'(occ_reg) >= cap);
    assign clock_new = sat_inc(clock_reg);
    assign insert_ok = table_full ? vic_found_reg : free_found_reg;
    assign insert_slot = table_full ? vic_slot_reg : free_slot_reg;

    assign wr_en = cmd.update_en && !cap_zero &&
                   (hit_found_reg || ((item_kind_reg == KIND_PUT) && insert_ok));
    assign wr_slot = hit_found_reg ? hit_slot_reg : insert_slot;
    assign wr_data = (item_kind_reg == KIND_PUT) ? item_data_reg : hit_data_reg;
    assign wr_count = hit_found_reg ? sat_inc(hit_count_reg) : CNT_ONE;
    assign occ_inc = wr_en && !hit_found_reg && !table_full;

    always_comb
    begin
        valid_next = valid_reg;
        if (wr_en)
        begin
            valid_next[wr_slot] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= CAP_RESET;
            clock_reg <= '0;
            occ_reg <= '0;
            valid_reg <= '0;
            scan_idx_reg <= '0;
            hit_found_reg <= 1'b0;
            vic_found_reg <= 1'b0;
            free_found_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                cfg_reg <= cfg_wr_data;
            end
            valid_reg <= valid_next;
            if (cmd.update_en && !cap_zero)
            begin
                clock_reg <= clock_new;
            end
            if (occ_inc)
            begin
                occ_reg <= occ_reg + OCC_W'(1);
            end
            if (cmd.start)
            begin
                scan_idx_reg <= '0;
                hit_found_reg <= 1'b0;
                vic_found_reg <= 1'b0;
                free_found_reg <= 1'b0;
            end
            else if (cmd.scan_en)
            begin
                scan_idx_reg <= scan_idx_reg + IDX_W'(1);
                if (key_match && !hit_found_reg)
                begin
                    hit_found_reg <= 1'b1;
                end
                if (better_victim)
                begin
                    vic_found_reg <= 1'b1;
                end
                if (!cur_valid && !free_found_reg)
                begin
                    free_found_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            item_kind_reg <= in_kind;
            item_key_reg <= in_key;
            item_data_reg <= in_data;
        end
        if (cmd.scan_en)
        begin
            if (key_match && !hit_found_reg)
            begin
                hit_slot_reg <= scan_idx_reg;
                hit_data_reg <= cur_data;
                hit_count_reg <= cur_count;
            end
            if (better_victim)
            begin
                vic_slot_reg <= scan_idx_reg;
                vic_count_reg <= cur_count;
                vic_stamp_reg <= cur_stamp;
            end
            if (!cur_valid && !free_found_reg)
            begin
                free_slot_reg <= scan_idx_reg;
            end
        end
        if (wr_en)
        begin
            key_mem[wr_slot] <= item_key_reg;
            data_mem[wr_slot] <= wr_data;
            count_mem[wr_slot] <= wr_count;
            stamp_mem[wr_slot] <= clock_new;
        end
        if (cmd.update_en)
        begin
            out_hit_reg <= !cap_zero && hit_found_reg;
            if (!cap_zero && hit_found_reg && (item_kind_reg == KIND_GET))
            begin
                out_data_reg <= hit_data_reg;
            end
            else
            begin
                out_data_reg <= MISS_DATA;
            end
        end
    end

    assign out_hit = out_hit_reg;
    assign out_data = out_data_reg;

endmodule

/* design/lfu_cache_table_top.sv */
// The edge that accepts a transaction starts the 16-slot scan, one slot per cycle through
// a single compare unit; a write-back then registers the result once the output is free.
// A new transaction is taken only when the controller is back in idle after the write-back.
// Reset clears the valid bits, use clock and occupancy at once and sets the capacity to 16;
// there is no clearing pass.
// Top level of the LFU cache table; depends on lfu_pkg, lfu_ctrl and lfu_datapath.
module lfu_cache_table_top (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_wr_en,
    input  logic [lfu_pkg::CFG_W-1:0]          cfg_wr_data,   // entries_in_use
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    input  logic [lfu_pkg::IN_TDATA_W-1:0]     s_axis_tdata,  // lookup_key, write_data
    input  logic                               s_axis_tuser,  // kind
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    output logic signed [lfu_pkg::DATA_W-1:0]  m_axis_tdata,  // read_data
    output logic                               m_axis_tuser   // hit
);
    import lfu_pkg::*;

    ctrl_cmd_t    cmd;
    ctrl_status_t status;
    logic signed [DATA_W-1:0] in_key;
    logic signed [DATA_W-1:0] in_data;

    assign in_key = s_axis_tdata[DATA_W-1:0];
    assign in_data = s_axis_tdata[2*DATA_W-1:DATA_W];

    lfu_ctrl u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .s_valid (s_axis_tvalid),
        .s_ready (s_axis_tready),
        .m_valid (m_axis_tvalid),
        .m_ready (m_axis_tready),
        .status  (status),
        .cmd     (cmd)
    );

    lfu_datapath u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .status      (status),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_kind     (s_axis_tuser),
        .in_key      (in_key),
        .in_data     (in_data),
        .out_hit     (m_axis_tuser),
        .out_data    (m_axis_tdata)
    );

endmodule
